FILE: hdl/tas_pkg.sv
// ----------------------------------------------------------------------------
// tas_pkg: shared types and constants of the trapezoid acceleration selector
// Field widths, register indexes, decision codes and the stage records that
// travel between the pipeline modules.
// ----------------------------------------------------------------------------
package tas_pkg;

  localparam int DATA_W    = 32;  // signed Q16.16 fields
  localparam int CFG_W     = 31;  // limit registers
  localparam int TICK_W    = 17;  // tick period register
  localparam int FRAC_W    = 16;  // fraction bits of Q16.16
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_W-1:0]  ACCEL_RESET = 31'd65536;
  localparam logic [CFG_W-1:0]  DECEL_RESET = 31'd65536;
  localparam logic [CFG_W-1:0]  VLIM_RESET  = 31'd65536;
  localparam logic [TICK_W-1:0] TICK_RESET  = 17'd66;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ACCEL_LIMIT    = 2'd0,
    CFG_DECEL_LIMIT    = 2'd1,
    CFG_VELOCITY_LIMIT = 2'd2,
    CFG_TICK_PERIOD    = 2'd3
  } cfg_index_t;

  typedef enum logic [3:0] {
    CODE_ARRIVED_STOP  = 4'd0,
    CODE_ARRIVED_BRAKE = 4'd1,
    CODE_CRUISE_HOLD   = 4'd2,
    CODE_CRUISE_ACCEL  = 4'd3,
    CODE_VEL_CHASE     = 4'd4,
    CODE_DIST_ACCEL    = 4'd5,
    CODE_LIMIT_HOLD    = 4'd6,
    CODE_REV_STOP      = 4'd7,
    CODE_REV_BRAKE     = 4'd8
  } decision_t;

  typedef struct packed {
    logic [CFG_W-1:0]  accel;
    logic [CFG_W-1:0]  decel;
    logic [CFG_W-1:0]  vlim;
    logic [TICK_W-1:0] tick;
  } cfg_t;

  // Products of the registers alone, refreshed every cycle.
  typedef struct packed {
    logic [CFG_W+TICK_W-1:0] accel_tick;     // a*T
    logic [CFG_W+TICK_W:0]   arrive_thresh;  // 2*vm*T
    logic [2*CFG_W-1:0]      vlim_sq;        // vm^2
  } derived_t;

  typedef struct packed {
    logic dist_neg;
    logic vel_pos;
    logic toward;
    logic chase_neg;
    logic at_limit;
  } flags_t;

  typedef struct packed {
    logic [DATA_W-1:0] dist_mag;
    logic [DATA_W-1:0] vel_mag;
    logic [DATA_W-1:0] tgt_mag;
    logic [CFG_W-1:0]  spd;        // min(|v0|, vm)
    flags_t            flags;
  } front_t;

  typedef struct packed {
    logic [2*CFG_W-1:0]  spd_sq;
    logic [2*DATA_W-2:0] tgt_sq;
    logic [2*CFG_W-1:0]  room_half;  // a*d
    logic                arrive;
    logic                slow;
    flags_t              flags;
  } prod_t;

  function automatic logic [DATA_W-1:0] apply_sign(input logic [CFG_W-1:0] m,
                                                   input logic neg);
    logic [DATA_W-1:0] ext;
    ext = {1'b0, m};
    return neg ? (DATA_W'(0) - ext) : ext;
  endfunction

endpackage

FILE: hdl/tas_in_if.sv
// ----------------------------------------------------------------------------
// tas_in_if: sample channel of the trapezoid acceleration selector
// Valid/ready channel carrying distance, present velocity and target velocity.
// ----------------------------------------------------------------------------
interface tas_in_if;
  import tas_pkg::*;

  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] remaining_distance;
  logic signed [DATA_W-1:0] current_velocity;
  logic signed [DATA_W-1:0] target_velocity;

  modport source (
    output valid, remaining_distance, current_velocity, target_velocity,
    input  ready
  );

  modport sink (
    input  valid, remaining_distance, current_velocity, target_velocity,
    output ready
  );
endinterface

FILE: hdl/tas_out_if.sv
// ----------------------------------------------------------------------------
// tas_out_if: command channel of the trapezoid acceleration selector
// Valid/ready channel carrying the acceleration command and decision code.
// ----------------------------------------------------------------------------
interface tas_out_if;
  import tas_pkg::*;

  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] accel_command;
  decision_t                decision_code;

  modport source (
    output valid, accel_command, decision_code,
    input  ready
  );

  modport sink (
    input  valid, accel_command, decision_code,
    output ready
  );
endinterface

FILE: hdl/trapezoid_accel_selector.sv
// ----------------------------------------------------------------------------
// trapezoid_accel_selector: one-axis acceleration selector, top level
// Picks a trapezoidal-profile acceleration command and decision code for
// each sample, comparing squared-velocity budgets against 2*a*d.
//
//   Channel   Dir  Handshake      Payload
//   in_ch     in   valid/ready    remaining_distance, current_velocity,
//                                 target_velocity
//   out_ch    out  valid/ready    accel_command, decision_code
//   cfg_*     in   write enable   cfg_index, cfg_wdata
//
// One beat per cycle while out_ch does not stall; a result passes through the
// input, product, difference and result registers in that order.
// rst_n is synchronous; it empties the pipeline and loads the register
// defaults. A register write applies to beats accepted after it.
// A stall on out_ch backs up stage by stage; empty stages keep taking beats.
// ----------------------------------------------------------------------------
module trapezoid_accel_selector (
  input  logic                          clk,
  input  logic                          rst_n,
  tas_in_if.sink                        in_ch,
  tas_out_if.source                     out_ch,
  input  logic                          cfg_wr_en,
  input  logic [tas_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [tas_pkg::CFG_W-1:0]     cfg_wdata
);
  import tas_pkg::*;

  cfg_t     cfg;
  derived_t derived;
  front_t   front;
  prod_t    prod;
  logic [DATA_W-1:0] accel_command;
  decision_t         decision_code;

  logic front_vld_r, prod_vld_r, diff_vld_r, out_vld_r;
  logic en_front, en_prod, en_diff, en_out;

  assign en_out   = !out_vld_r   || out_ch.ready;
  assign en_diff  = !diff_vld_r  || en_out;
  assign en_prod  = !prod_vld_r  || en_diff;
  assign en_front = !front_vld_r || en_prod;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      front_vld_r <= 1'b0;
      prod_vld_r  <= 1'b0;
      diff_vld_r  <= 1'b0;
      out_vld_r   <= 1'b0;
    end else begin
      if (en_front) front_vld_r <= in_ch.valid;
      if (en_prod)  prod_vld_r  <= front_vld_r;
      if (en_diff)  diff_vld_r  <= prod_vld_r;
      if (en_out)   out_vld_r   <= diff_vld_r;
    end
  end

  tas_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg),
    .derived   (derived)
  );

  tas_front u_front (
    .clk                (clk),
    .en                 (en_front),
    .remaining_distance (in_ch.remaining_distance),
    .current_velocity   (in_ch.current_velocity),
    .target_velocity    (in_ch.target_velocity),
    .vlim               (cfg.vlim),
    .front              (front)
  );

  tas_mult u_mult (
    .clk     (clk),
    .en      (en_prod),
    .front   (front),
    .cfg     (cfg),
    .derived (derived),
    .prod    (prod)
  );

  tas_decide u_decide (
    .clk           (clk),
    .en_diff       (en_diff),
    .en_out        (en_out),
    .prod          (prod),
    .cfg           (cfg),
    .derived       (derived),
    .accel_command (accel_command),
    .decision_code (decision_code)
  );

  assign in_ch.ready          = en_front;
  assign out_ch.valid         = out_vld_r;
  assign out_ch.accel_command = accel_command;
  assign out_ch.decision_code = decision_code;

  // Back-pressure reaches the input only when every stage holds a beat.
  a_full_when_blocked: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ch.ready |-> (front_vld_r && prod_vld_r && diff_vld_r && out_vld_r))
    else $error("input stalled with an empty pipeline stage");

  a_accept_fills_front: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> front_vld_r)
    else $error("accepted beat did not reach the input stage");

  a_hold_codes_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && (out_ch.decision_code == CODE_ARRIVED_STOP ||
                      out_ch.decision_code == CODE_CRUISE_HOLD ||
                      out_ch.decision_code == CODE_LIMIT_HOLD ||
                      out_ch.decision_code == CODE_REV_STOP))
    |-> (out_ch.accel_command == '0))
    else $error("hold decision with nonzero command");

  a_reset_empties: assert property (@(posedge clk)
    !rst_n |=> !out_ch.valid)
    else $error("result valid right after reset");
endmodule

FILE: hdl/tas_cfg_regs.sv
// ----------------------------------------------------------------------------
// tas_cfg_regs: configuration registers and their derived products
// Holds the four limits and registers a*T, 2*vm*T and vm^2 from them.
// ----------------------------------------------------------------------------
module tas_cfg_regs (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_wr_en,
  input  logic [tas_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [tas_pkg::CFG_W-1:0]       cfg_wdata,
  output tas_pkg::cfg_t                   cfg,
  output tas_pkg::derived_t               derived
);
  import tas_pkg::*;

  cfg_t     cfg_r;
  derived_t derived_r;
  logic [CFG_W+TICK_W-1:0] vlim_tick;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.accel <= ACCEL_RESET;
      cfg_r.decel <= DECEL_RESET;
      cfg_r.vlim  <= VLIM_RESET;
      cfg_r.tick  <= TICK_RESET;
    end else if (cfg_wr_en) begin
      case (cfg_index_t'(cfg_index))
        CFG_ACCEL_LIMIT:    cfg_r.accel <= cfg_wdata;
        CFG_DECEL_LIMIT:    cfg_r.decel <= cfg_wdata;
        CFG_VELOCITY_LIMIT: cfg_r.vlim  <= cfg_wdata;
        CFG_TICK_PERIOD:    cfg_r.tick  <= cfg_wdata[TICK_W-1:0];
        default: ;
      endcase
    end
  end

  assign vlim_tick = cfg_r.vlim * cfg_r.tick;

  // The user must keep the block idle around a write; the block does not enforce
  // it. Only then is the lag of these registered products never seen by a sample.
  always_ff @(posedge clk) begin
    derived_r.accel_tick    <= cfg_r.accel * cfg_r.tick;
    derived_r.arrive_thresh <= {vlim_tick, 1'b0};
    derived_r.vlim_sq       <= cfg_r.vlim * cfg_r.vlim;
  end

  assign cfg     = cfg_r;
  assign derived = derived_r;
endmodule

FILE: hdl/tas_front.sv
// ----------------------------------------------------------------------------
// tas_front: input stage
// Captures a sample as magnitudes, clamped speed and direction flags.
// ----------------------------------------------------------------------------
module tas_front (
  input  logic                      clk,
  input  logic                      en,
  input  logic [tas_pkg::DATA_W-1:0] remaining_distance,
  input  logic [tas_pkg::DATA_W-1:0] current_velocity,
  input  logic [tas_pkg::DATA_W-1:0] target_velocity,
  input  logic [tas_pkg::CFG_W-1:0]  vlim,
  output tas_pkg::front_t            front
);
  import tas_pkg::*;

  front_t            front_r;
  front_t            front_nxt;
  logic [DATA_W:0]   chase_diff;
  logic              over_limit;

  always_comb begin
    front_nxt.dist_mag = remaining_distance[DATA_W-1] ?
                         (DATA_W'(0) - remaining_distance) : remaining_distance;
    front_nxt.vel_mag  = current_velocity[DATA_W-1] ?
                         (DATA_W'(0) - current_velocity) : current_velocity;
    front_nxt.tgt_mag  = target_velocity[DATA_W-1] ?
                         (DATA_W'(0) - target_velocity) : target_velocity;

    over_limit    = (front_nxt.vel_mag >= {1'b0, vlim});
    front_nxt.spd = over_limit ? vlim : front_nxt.vel_mag[CFG_W-1:0];

    chase_diff = {target_velocity[DATA_W-1], target_velocity}
               - {current_velocity[DATA_W-1], current_velocity};

    front_nxt.flags.dist_neg  = remaining_distance[DATA_W-1];
    front_nxt.flags.vel_pos   = !current_velocity[DATA_W-1] &&
                                (current_velocity != '0);
    // Zero velocity counts as moving toward the goal.
    front_nxt.flags.toward    = (current_velocity == '0) ||
                                (remaining_distance[DATA_W-1] ==
                                 current_velocity[DATA_W-1]);
    front_nxt.flags.chase_neg = chase_diff[DATA_W];
    front_nxt.flags.at_limit  = over_limit;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      front_r <= front_nxt;
    end
  end

  assign front = front_r;
endmodule

FILE: hdl/tas_mult.sv
// ----------------------------------------------------------------------------
// tas_mult: product stage
// Squares the speeds, forms a*d and makes the arrival and slow-speed tests.
// ----------------------------------------------------------------------------
module tas_mult (
  input  logic                clk,
  input  logic                en,
  input  tas_pkg::front_t     front,
  input  tas_pkg::cfg_t       cfg,
  input  tas_pkg::derived_t   derived,
  output tas_pkg::prod_t      prod
);
  import tas_pkg::*;

  prod_t                  prod_r;
  prod_t                  prod_nxt;
  logic [2*DATA_W-1:0]    tgt_sq_full;
  logic [CFG_W+DATA_W-1:0] room_full;

  always_comb begin
    tgt_sq_full = front.tgt_mag * front.tgt_mag;
    room_full   = cfg.accel * front.dist_mag;

    prod_nxt.spd_sq    = front.spd * front.spd;
    prod_nxt.tgt_sq    = tgt_sq_full[2*DATA_W-2:0];
    prod_nxt.room_half = room_full[2*CFG_W-1:0];
    prod_nxt.arrive    = ({1'b0, front.dist_mag, FRAC_W'(0)} <= derived.arrive_thresh);
    prod_nxt.slow      = ({front.vel_mag, FRAC_W'(0)} <= derived.accel_tick);
    prod_nxt.flags     = front.flags;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prod_r <= prod_nxt;
    end
  end

  assign prod = prod_r;
endmodule

FILE: hdl/tas_decide.sv
// ----------------------------------------------------------------------------
// tas_decide: difference and decision stages
// Forms the squared-velocity budgets, then picks the code and the command
// and holds them in the result register.
// ----------------------------------------------------------------------------
module tas_decide (
  input  logic                         clk,
  input  logic                         en_diff,
  input  logic                         en_out,
  input  tas_pkg::prod_t               prod,
  input  tas_pkg::cfg_t                cfg,
  input  tas_pkg::derived_t            derived,
  output logic [tas_pkg::DATA_W-1:0]   accel_command,
  output tas_pkg::decision_t           decision_code
);
  import tas_pkg::*;

  localparam int SQ_W = 2 * DATA_W - 1;  // widest square

  // Difference stage.
  logic [2*DATA_W-1:0] need_sum_r;
  logic [SQ_W-1:0]     need_tgt_r;
  logic [SQ_W-1:0]     room_r;
  logic                arrive_r;
  logic                slow_r;
  flags_t              flags_r;

  logic [SQ_W-1:0]     vm2;
  logic [SQ_W-1:0]     s2;
  logic [SQ_W-1:0]     need_acc;
  logic [SQ_W-1:0]     need_dec;
  logic [SQ_W-1:0]     need_tgt;

  always_comb begin
    vm2      = {1'b0, derived.vlim_sq};
    s2       = {1'b0, prod.spd_sq};
    need_acc = vm2 - s2;  // speed never exceeds the limit here
    need_dec = (vm2 >= prod.tgt_sq) ? (vm2 - prod.tgt_sq) : (prod.tgt_sq - vm2);
    need_tgt = (prod.tgt_sq >= s2) ? (prod.tgt_sq - s2) : (s2 - prod.tgt_sq);
  end

  always_ff @(posedge clk) begin
    if (en_diff) begin
      need_sum_r <= {1'b0, need_acc} + {1'b0, need_dec};
      need_tgt_r <= need_tgt;
      room_r     <= {prod.room_half, 1'b0};
      arrive_r   <= prod.arrive;
      slow_r     <= prod.slow;
      flags_r    <= prod.flags;
    end
  end

  // Decision stage.
  logic [DATA_W-1:0] cmd_r;
  logic [DATA_W-1:0] cmd_nxt;
  decision_t         code_r;
  decision_t         code_nxt;
  logic              fits;
  logic              chase;

  always_comb begin
    fits     = (need_sum_r < {1'b0, room_r});
    chase    = (need_tgt_r >= room_r);
    cmd_nxt  = '0;
    code_nxt = CODE_LIMIT_HOLD;
    if (arrive_r) begin
      if (slow_r) begin
        code_nxt = CODE_ARRIVED_STOP;
      end else begin
        code_nxt = CODE_ARRIVED_BRAKE;
        cmd_nxt  = apply_sign(cfg.decel, flags_r.vel_pos);
      end
    end else if (flags_r.toward) begin
      if (fits) begin
        if (flags_r.at_limit) begin
          code_nxt = CODE_CRUISE_HOLD;
        end else begin
          code_nxt = CODE_CRUISE_ACCEL;
          cmd_nxt  = apply_sign(cfg.accel, flags_r.dist_neg);
        end
      end else if (chase) begin
        code_nxt = CODE_VEL_CHASE;
        cmd_nxt  = apply_sign(cfg.accel, flags_r.chase_neg);
      end else if (!flags_r.at_limit) begin
        code_nxt = CODE_DIST_ACCEL;
        cmd_nxt  = apply_sign(cfg.accel, flags_r.dist_neg);
      end else begin
        code_nxt = CODE_LIMIT_HOLD;
      end
    end else begin
      if (slow_r) begin
        code_nxt = CODE_REV_STOP;
      end else begin
        code_nxt = CODE_REV_BRAKE;
        cmd_nxt  = apply_sign(cfg.decel, flags_r.vel_pos);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en_out) begin
      cmd_r  <= cmd_nxt;
      code_r <= code_nxt;
    end
  end

  assign accel_command = cmd_r;
  assign decision_code = code_r;
endmodule

FILE: verif/trapezoid_accel_selector_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// trapezoid_accel_selector_tb: self-checking bench for the acceleration selector
// Walks a table of hand-picked samples, then several register settings with
// shaped random samples. Each command beat is compared with an independent
// prediction, and both channels idle and stall at random.
// ----------------------------------------------------------------------------
module trapezoid_accel_selector_tb;
  import tas_pkg::*;

  typedef logic [65:0] wide_t;

  typedef struct packed {
    logic [DATA_W-1:0] accel;
    decision_t         code;
  } cmd_t;

  typedef struct {
    logic signed [DATA_W-1:0] rdist;
    logic signed [DATA_W-1:0] vel;
    logic signed [DATA_W-1:0] tgt;
    logic                     typed;
    cmd_t                     want;
  } probe_t;

  localparam wide_t MAG_MAX         = 66'h7FFF_FFFF;
  localparam int    PHASES          = 10;
  localparam int    ITEMS_PER_PHASE = 70;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;
  logic                  cfg_wr_en;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_W-1:0]      cfg_wdata;

  tas_in_if  in_ch ();
  tas_out_if out_ch ();

  trapezoid_accel_selector dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // Register mirror, kept in step with every write.
  logic [CFG_W-1:0]  acc_lim;
  logic [CFG_W-1:0]  dec_lim;
  logic [CFG_W-1:0]  spd_lim;
  logic [TICK_W-1:0] tick_len;

  cmd_t pending_cmds[$];
  int   fault_count = 0;
  logic no_idle     = 1'b0;

  // Hand-picked samples under the reset registers: a = dc = vm = 1.0 and
  // T = 66, so the goal is reached within 132 and a speed up to 66 is stopped.
  // The limit-hold decision cannot occur: at the speed limit the two budgets
  // being compared are equal.
  probe_t probes [19] = '{
    '{32'sd0, 32'sd0, 32'sd0, 1'b1, '{32'h0000_0000, CODE_ARRIVED_STOP}},
    '{32'sd0, 32'h7FFF_FFFF, 32'sd0, 1'b1, '{32'hFFFF_0000, CODE_ARRIVED_BRAKE}},
    '{32'sd0, 32'h8000_0000, 32'sd0, 1'b1, '{32'h0001_0000, CODE_ARRIVED_BRAKE}},
    '{32'sd132, 32'sd66, 32'sd0, 1'b1, '{32'h0000_0000, CODE_ARRIVED_STOP}},
    '{-32'sd132, 32'sd67, 32'sd0, 1'b1, '{32'hFFFF_0000, CODE_ARRIVED_BRAKE}},
    '{32'sd133, 32'sd0, 32'sd0, 1'b0, '{32'h0, CODE_ARRIVED_STOP}},
    '{32'h7FFF_FFFF, 32'sd65536, 32'sd65536, 1'b1, '{32'h0, CODE_CRUISE_HOLD}},
    '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0, '{32'h0, CODE_ARRIVED_STOP}},
    '{32'h7FFF_FFFF, 32'sd1000, 32'sd0, 1'b1, '{32'h0001_0000, CODE_CRUISE_ACCEL}},
    '{32'h8000_0000, -32'sd1000, 32'sd0, 1'b1, '{32'hFFFF_0000, CODE_CRUISE_ACCEL}},
    '{32'sd200, 32'sd0, 32'h7FFF_FFFF, 1'b0, '{32'h0, CODE_ARRIVED_STOP}},
    '{-32'sd200, -32'sd10, 32'h8000_0000, 1'b0, '{32'h0, CODE_ARRIVED_STOP}},
    '{32'sd200, 32'sd10, 32'h8000_0000, 1'b0, '{32'h0, CODE_ARRIVED_STOP}},
    '{32'h7FFF_FFFF, -32'sd5, 32'sd0, 1'b1, '{32'h0000_0000, CODE_REV_STOP}},
    '{32'h7FFF_FFFF, 32'h8000_0000, 32'sd0, 1'b1, '{32'h0001_0000, CODE_REV_BRAKE}},
    '{32'h8000_0000, 32'h7FFF_FFFF, 32'sd0, 1'b1, '{32'hFFFF_0000, CODE_REV_BRAKE}},
    '{-32'sd133, 32'sd66, 32'sd0, 1'b1, '{32'h0000_0000, CODE_REV_STOP}},
    '{32'sd1000, 32'sd600, 32'sd600, 1'b0, '{32'h0, CODE_ARRIVED_STOP}},
    '{32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b0, '{32'h0, CODE_ARRIVED_STOP}}
  };

  initial begin
    forever #2 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("trapezoid_accel_selector verification failed");
    $finish;
  end

  function automatic wide_t magnitude(input logic signed [DATA_W-1:0] x);
    wide_t w;
    w = {{34{x[DATA_W-1]}}, x};
    return x[DATA_W-1] ? -w : w;
  endfunction

  function automatic wide_t spread(input wide_t p, input wide_t q);
    return (p >= q) ? p - q : q - p;
  endfunction

  function automatic wide_t cap31(input wide_t x);
    return (x > MAG_MAX) ? MAG_MAX : x;
  endfunction

  function automatic logic [DATA_W-1:0] with_sign(input logic [CFG_W-1:0] m, input logic neg);
    return neg ? ~{1'b0, m} + 32'd1 : {1'b0, m};
  endfunction

  // Expected command for one sample under the mirrored registers.
  function automatic cmd_t select_accel(input logic signed [DATA_W-1:0] rdist,
                                        input logic signed [DATA_W-1:0] vel,
                                        input logic signed [DATA_W-1:0] tgt);
    wide_t d, sv, s, s2, vm2, t2, room, need_acc, need_dec, need_tgt;
    logic  slow, at_limit;
    cmd_t  r;
    d  = magnitude(rdist);
    sv = magnitude(vel);
    slow = (sv << 16) <= wide_t'(acc_lim) * tick_len;
    r.accel = '0;
    r.code  = CODE_ARRIVED_STOP;
    if ((d << 16) <= ((wide_t'(spd_lim) * tick_len) << 1)) begin
      if (!slow) begin
        r.code  = CODE_ARRIVED_BRAKE;
        r.accel = with_sign(dec_lim, vel > 0);
      end
    end else if (vel == 0 || rdist[DATA_W-1] == vel[DATA_W-1]) begin
      s        = (sv > wide_t'(spd_lim)) ? wide_t'(spd_lim) : sv;
      s2       = s * s;
      vm2      = wide_t'(spd_lim) * spd_lim;
      t2       = magnitude(tgt) * magnitude(tgt);
      room     = (wide_t'(acc_lim) * d) << 1;
      need_acc = vm2 - s2;
      need_dec = spread(vm2, t2);
      need_tgt = spread(t2, s2);
      at_limit = (s == wide_t'(spd_lim));
      if (need_acc + need_dec < room) begin
        if (at_limit) begin
          r.code = CODE_CRUISE_HOLD;
        end else begin
          r.code  = CODE_CRUISE_ACCEL;
          r.accel = with_sign(acc_lim, rdist[DATA_W-1]);
        end
      end else if (need_tgt >= room) begin
        r.code  = CODE_VEL_CHASE;
        r.accel = with_sign(acc_lim, tgt < vel);
      end else if (!at_limit) begin
        r.code  = CODE_DIST_ACCEL;
        r.accel = with_sign(acc_lim, rdist[DATA_W-1]);
      end else begin
        r.code = CODE_LIMIT_HOLD;
      end
    end else begin
      if (slow) begin
        r.code = CODE_REV_STOP;
      end else begin
        r.code  = CODE_REV_BRAKE;
        r.accel = with_sign(dec_lim, vel > 0);
      end
    end
    return r;
  endfunction

  // Speed magnitudes clustered around the speed limit and the stop threshold.
  function automatic wide_t pick_speed();
    wide_t vm, knee;
    vm   = spd_lim;
    knee = (wide_t'(acc_lim) * tick_len) >> 16;
    case ($urandom_range(0, 7))
      0: return '0;
      1: return vm;
      2: return cap31(vm + 1);
      3: return cap31(vm - 1);
      4: return $urandom_range(0, 32'(vm));
      5: return cap31(knee + $urandom_range(0, 1));
      6: return $urandom & 32'h7FFF_FFFF;
      default: return cap31((vm << 1) - $urandom_range(0, 32'(vm)));
    endcase
  endfunction

  function automatic logic [CFG_W-1:0] pick_limit();
    int          w;
    logic [31:0] v;
    w = $urandom_range(1, 31);
    v = $urandom & ((32'h1 << w) - 32'h1);
    return (v == 0) ? 31'd1 : v[CFG_W-1:0];
  endfunction

  // Most samples put the distance right at a decision boundary: the arrival
  // edge, or the distance where 2*a*d meets one of the velocity budgets.
  function automatic void shape_sample(output logic signed [DATA_W-1:0] rdist,
                                       output logic signed [DATA_W-1:0] vel,
                                       output logic signed [DATA_W-1:0] tgt);
    wide_t dmag, vmag, tmag, s, vm2, budget, reach;
    logic  dneg, vneg, tneg;
    int    kind;
    kind = $urandom_range(0, 9);
    dneg = $urandom_range(0, 1);
    tneg = $urandom_range(0, 1);
    vneg = dneg;
    vmag = pick_speed();
    tmag = pick_speed();
    reach = cap31(((wide_t'(spd_lim) * tick_len) << 1) >> 16);
    vm2   = wide_t'(spd_lim) * spd_lim;
    s     = (vmag > wide_t'(spd_lim)) ? wide_t'(spd_lim) : vmag;
    if (kind < 2) begin
      rdist = $urandom;
      vel   = $urandom;
      tgt   = $urandom;
      return;
    end else if (kind == 2) begin
      vneg = $urandom_range(0, 1);
      dmag = $urandom_range(0, 1) ? wide_t'($urandom_range(0, 32'(reach)))
                                  : cap31(reach + $urandom_range(0, 1));
    end else if (kind == 9) begin
      vneg = !dneg;
      dmag = cap31(reach + 1 + ($urandom_range(0, 1) ? ($urandom & 32'hFFFF)
                                                     : ($urandom & 32'h7FFF_FFFF)));
    end else begin
      budget = (kind < 6) ? (vm2 - s * s) + spread(vm2, tmag * tmag)
                          : spread(tmag * tmag, s * s);
      dmag = cap31(budget / (wide_t'(acc_lim) << 1) + $urandom_range(0, 4));
      dmag = (dmag >= 2) ? dmag - 2 : '0;
    end
    rdist = 32'(dneg ? -dmag : dmag);
    vel   = 32'(vneg ? -vmag : vmag);
    tgt   = 32'(tneg ? -tmag : tmag);
  endfunction

  task automatic write_reg(input cfg_index_t idx, input logic [CFG_W-1:0] value);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    case (idx)
      CFG_ACCEL_LIMIT:    acc_lim  = value;
      CFG_DECEL_LIMIT:    dec_lim  = value;
      CFG_VELOCITY_LIMIT: spd_lim  = value;
      CFG_TICK_PERIOD:    tick_len = value[TICK_W-1:0];
      default: ;
    endcase
  endtask

  // Offers one sample beat and records its expected command once accepted.
  task automatic send_sample(input logic signed [DATA_W-1:0] rdist,
                             input logic signed [DATA_W-1:0] vel,
                             input logic signed [DATA_W-1:0] tgt,
                             input logic typed, input cmd_t typed_cmd);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 14);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid              <= 1'b1;
    in_ch.remaining_distance <= rdist;
    in_ch.current_velocity   <= vel;
    in_ch.target_velocity    <= tgt;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    pending_cmds.push_back(typed ? typed_cmd : select_accel(rdist, vel, tgt));
  endtask

  initial begin : sample_side
    logic signed [DATA_W-1:0] d, v, t;
    logic [CFG_W-1:0]         a_set, dc_set, vm_set, tick_word;
    in_ch.valid              = 1'b0;
    in_ch.remaining_distance = '0;
    in_ch.current_velocity   = '0;
    in_ch.target_velocity    = '0;
    cfg_wr_en                = 1'b0;
    cfg_index                = CFG_ACCEL_LIMIT;
    cfg_wdata                = '0;
    acc_lim  = ACCEL_RESET;
    dec_lim  = DECEL_RESET;
    spd_lim  = VLIM_RESET;
    tick_len = TICK_RESET;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    foreach (probes[i])
      send_sample(probes[i].rdist, probes[i].vel, probes[i].tgt, probes[i].typed,
                  probes[i].want);

    for (int p = 0; p < PHASES; p++) begin
      // Registers change only with the pipeline empty.
      in_ch.valid <= 1'b0;
      while (pending_cmds.size() != 0) @(posedge clk);
      a_set     = pick_limit();
      dc_set    = pick_limit();
      vm_set    = pick_limit();
      tick_word = $urandom_range(0, 65536);
      case (p)
        0: begin
          a_set = 31'd1; dc_set = 31'd1; vm_set = 31'd1; tick_word = '0;
        end
        1: begin
          a_set = 31'h7FFF_FFFF; dc_set = 31'h7FFF_FFFF; vm_set = 31'h7FFF_FFFF;
          tick_word = 31'd65536;
        end
        // Upper bits of a tick write are dropped, leaving the widest period.
        2: tick_word = 31'h7FFF_FFFF;
        3: begin
          a_set = ACCEL_RESET; dc_set = DECEL_RESET; vm_set = VLIM_RESET;
          tick_word = TICK_RESET;
        end
        default: ;
      endcase
      write_reg(CFG_ACCEL_LIMIT, a_set);
      write_reg(CFG_DECEL_LIMIT, dc_set);
      write_reg(CFG_VELOCITY_LIMIT, vm_set);
      write_reg(CFG_TICK_PERIOD, tick_word);
      cfg_wr_en <= 1'b0;
      no_idle = (p == 4) || ($urandom_range(0, 3) == 0);
      repeat (ITEMS_PER_PHASE) begin
        shape_sample(d, v, t);
        send_sample(d, v, t, 1'b0, '0);
      end
    end

    in_ch.valid <= 1'b0;
    while (pending_cmds.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
    if (fault_count == 0) begin
      $display("trapezoid_accel_selector verification clean");
    end else begin
      $display("trapezoid_accel_selector verification failed");
    end
    $finish;
  end

  initial begin : command_side
    int hold;
    out_ch.ready = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      hold = no_idle ? 0 : $urandom_range(0, 14);
      if (hold > 0) begin
        out_ch.ready <= 1'b0;
        repeat (hold) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      @(posedge clk);
      while (!out_ch.valid) @(posedge clk);
    end
  end

  always @(posedge clk) begin
    cmd_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_cmds.size() == 0) begin
        fault_count++;
        if (fault_count <= 10)
          $display("unexpected command beat: accel %h code %0d",
                   out_ch.accel_command, out_ch.decision_code);
      end else begin
        want = pending_cmds.pop_front();
        if (out_ch.accel_command !== want.accel || out_ch.decision_code !== want.code) begin
          fault_count++;
          if (fault_count <= 10)
            $display("command mismatch: expected accel %h code %0d, got accel %h code %0d",
                     want.accel, want.code, out_ch.accel_command, out_ch.decision_code);
        end
      end
    end
  end

endmodule
